FILE: rtl/core/shbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbf_pkg
// Shared types, constants and the per-character mixing function of the
// string hash bucket fold core.
// ----------------------------------------------------------------------------
package shbf_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned HashW     = 32;
  localparam int unsigned FoldW     = 31;
  localparam int unsigned CountW    = 16;
  localparam int unsigned StepCntW  = 5;
  localparam logic [CountW-1:0] CountReset = 16'd1024;
  // One quotient bit per step across the whole folded value
  localparam logic [StepCntW-1:0] DivLastStep = StepCntW'(FoldW - 1);

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 7;
  localparam int unsigned ShiftC = 3;
  localparam int unsigned RotL   = 2;

  // Controller to datapath commands
  typedef struct packed {
    logic mix;        // take one character into the running hash
    logic clr_val;    // force the fold value to zero
    logic div_start;  // load the divider from the fold value
    logic div_step;   // one restoring division step
    logic sum_load;   // fold value <= quotient + remainder
    logic out_load;   // copy fold value into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic m_small;    // bucket count is zero or one
    logic val_ge_m;   // fold value still at or above the bucket count
    logic div_last;   // current division step is the final one
  } stat_t;

  // Mix one character into the running hash
  function automatic logic [HashW-1:0] mix_char(input logic [HashW-1:0] v_in,
                                                input logic [CharW-1:0] c);
    logic [HashW-1:0] c32;
    logic [HashW-1:0] v;
    c32 = {{(HashW-CharW){1'b0}}, c};
    v = v_in ^ (c32 << ShiftA);
    v = v + (c32 << ShiftB);
    v = v ^ c32;
    v = v ^ (c32 >> ShiftC);
    return {v[HashW-RotL-1:0], v[HashW-1:HashW-RotL]};
  endfunction

endpackage

FILE: rtl/core/shbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbf_ctrl
// Sequencer: accepts characters, runs the fold passes on the closing
// character and hands the bucket to the output register.
// ----------------------------------------------------------------------------
module shbf_ctrl
  import shbf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  output logic  in_ready_o,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.mix = 1'b1;
          if (in_last_i) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat_i.m_small) begin
          cmd_o.clr_val = 1'b1;
          state_d = ST_DONE;
        end else if (stat_i.val_ge_m) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_load = 1'b1;
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/shbf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbf_datapath
// Running hash, bucket count register, restoring divider for the fold
// passes and the output register.
// ----------------------------------------------------------------------------
module shbf_datapath
  import shbf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic [CharW-1:0]  char_i,
  input  logic              last_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [CountW-1:0] bucket_o,
  output logic [CountW-1:0] bucket_count_o
);

  logic [CountW-1:0]   count_q;
  logic [HashW-1:0]    hash_q;
  logic [HashW-1:0]    mixed;
  logic [FoldW-1:0]    val_q;
  logic [FoldW-1:0]    quot_q;
  logic [CountW-1:0]   rem_q;
  logic [StepCntW-1:0] cnt_q;
  logic [CountW-1:0]   bucket_q;
  logic [CountW:0]     shifted;
  logic [CountW:0]     diff;
  logic                ge;
  logic [FoldW-1:0]    sum;

  assign mixed   = mix_char(hash_q, char_i);
  assign shifted = {rem_q, quot_q[FoldW-1]};
  assign ge      = (shifted >= {1'b0, count_q});
  assign diff    = shifted - {1'b0, count_q};
  assign sum     = quot_q + {{(FoldW-CountW){1'b0}}, rem_q};

  assign stat_o.m_small  = (count_q <= CountW'(1));
  assign stat_o.val_ge_m = (val_q >= {{(FoldW-CountW){1'b0}}, count_q});
  assign stat_o.div_last = (cnt_q == DivLastStep);
  assign bucket_o        = bucket_q;
  assign bucket_count_o  = count_q;

  // Config register and running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      hash_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.mix) begin
        hash_q <= last_i ? '0 : mixed;
      end
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + StepCntW'(1);
      end
    end
  end

  // Fold value, divider and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.mix && last_i) begin
      val_q <= mixed[FoldW-1:0];
    end else if (cmd_i.clr_val) begin
      val_q <= '0;
    end else if (cmd_i.sum_load) begin
      val_q <= sum;
    end
    if (cmd_i.div_start) begin
      quot_q <= val_q;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[FoldW-2:0], ge};
      rem_q  <= ge ? diff[CountW-1:0] : shifted[CountW-1:0];
    end
    if (cmd_i.out_load) begin
      bucket_q <= val_q[CountW-1:0];
    end
  end

endmodule

FILE: rtl/core/string_hash_bucket_fold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_bucket_fold_core
// Hashes an identifier delivered one character per item, last character
// first, and folds the hash into a bucket below the configured count.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per item in tdata; tlast marks the
//   identifier's first character, which is delivered last and closes it.
//   m_axis returns one bucket per identifier. The user must drive cfg_we_i,
//   which writes the bucket count (reset 1024), only while the core is idle;
//   the core itself does not enforce this.
// Intake and fold:
//   A character without tlast is taken and the next may follow at once.
//   The closing character starts the fold, k passes of one check state,
//   31 restoring divider steps at one quotient bit per cycle and one sum
//   state (k is zero when the masked hash is already below the count).
//   s_axis_tready_o is low during the fold.
// Reset:
//   Clears the running hash, the controller and the output valid, and sets
//   the bucket count to 1024.
// Stall:
//   A bucket waits in the output register while m_axis_tready_i is low;
//   characters of the next identifier are still taken meanwhile, and the
//   next fold holds its result until the register frees up.
// ----------------------------------------------------------------------------
module string_hash_bucket_fold_core
  import shbf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,    // bucket_count
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CharW-1:0]  s_axis_tdata_i, // [7:0] char_code
  input  logic              s_axis_tlast_i, // end_of_id
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [CountW-1:0] m_axis_tdata_o  // [15:0] bucket
);

  cmd_t              cmd;
  stat_t             stat;
  logic [CountW-1:0] bucket_count;

  shbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  shbf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .char_i         (s_axis_tdata_i),
    .last_i         (s_axis_tlast_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .bucket_o       (m_axis_tdata_o),
    .bucket_count_o (bucket_count)
  );

`ifndef SYNTHESIS
  // A plain character never blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i |=> s_axis_tready_o)
    else $error("core stalled after a plain character");

  // A closing character starts the fold and stops intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("intake still open during fold");

  // A delivered bucket lies below a bucket count of two or more
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (bucket_count > CountW'(1)) |-> m_axis_tdata_o < bucket_count)
    else $error("bucket not below bucket count");

  // Small bucket counts fold to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (bucket_count <= CountW'(1)) |-> m_axis_tdata_o == '0)
    else $error("nonzero bucket for bucket count of one or zero");
`endif

endmodule
